>>> rtl/core/fss_pkg.sv
// Shared constants, types and a helper function for the fuzzy subsequence scorer.
package fss_pkg;

    // Bounds
    localparam int QUERY_MAX     = 16;
    localparam int CANDIDATE_MAX = 255;

    // Field widths
    localparam int CHAR_W  = 8;
    localparam int QLEN_W  = 5;
    localparam int QIDX_W  = 4;
    localparam int SCORE_W = 15;
    localparam int RUN_W   = 14;
    localparam int POS_W   = 8;
    localparam int STRK_W  = 5;
    localparam int CFG_W   = 64;
    localparam int CFG_IDX_W = 2;

    // Score constants
    localparam logic [RUN_W-1:0]   SCORE_START       = RUN_W'(4000);
    localparam logic [SCORE_W-1:0] SCORE_EXACT       = SCORE_W'(10000);
    localparam logic [15:0]        SCORE_PREFIX      = 16'd8000;
    localparam logic [SCORE_W-1:0] SCORE_EMPTY_QUERY = SCORE_W'(10);
    localparam logic [SCORE_W-1:0] SCORE_NONE        = '1;
    localparam logic [15:0]        BONUS_BASE        = 16'd20;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_QUERY_LOW  = 2'd0,
        CFG_QUERY_HIGH = 2'd1,
        CFG_QUERY_LEN  = 2'd2
    } cfg_idx_t;

    // Result kind codes
    typedef enum logic [2:0] {
        KIND_EMPTY    = 3'd0,
        KIND_EXACT    = 3'd1,
        KIND_PREFIX   = 3'd2,
        KIND_SUBSEQ   = 3'd3,
        KIND_NONE     = 3'd4,
        KIND_OVERLONG = 3'd5
    } kind_t;

    // Fold ASCII upper case letters to lower case
    function automatic logic [CHAR_W-1:0] fold_byte(input logic [CHAR_W-1:0] c);
        logic [CHAR_W-1:0] r;
        r = c;
        if (c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/fuzzy_subsequence_scorer_core.sv
// Fuzzy subsequence scorer: streams candidate bytes and scores them against a query.
//
// Usage:
//   The query is written through the plain write port (cfg_wr_en, cfg_index, cfg_wdata)
//   while the block is idle: index 0 holds query bytes 0..7, index 1 bytes 8..15,
//   index 2 the query length (values above 16 count as 16).
//   Candidate bytes arrive on the s_ stream, one item per byte; s_tlast marks the last
//   byte, and s_tuser set marks an item with no byte that ends the candidate as it is.
//   One result per candidate leaves on the m_ stream: score in m_tdata, kind in m_tuser.
// Timing:
//   An item is captured in an input register, scored from there against the running
//   candidate state, and a result lands in the output register. One item per cycle is
//   sustained while no held result blocks a final item, set by the single compare-and-add
//   update of the running score.
// Stalls:
//   While m_tready is low a held result blocks only the next final item; bytes that do
//   not end a candidate keep flowing. s_tready drops once the input register is stuck.
// Reset:
//   aresetn (synchronous, active low) empties both registers, clears the query to an
//   empty one and returns the candidate state to its start values.
module fuzzy_subsequence_scorer_core
    import fss_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration write port
    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata,
    // Candidate item stream
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [7:0]           s_tdata,   // [7:0] candidate_char
    input  logic                 s_tlast,   // last_char
    input  logic                 s_tuser,   // [0] empty_candidate
    // Result item stream
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [15:0]          m_tdata,   // [14:0] match_score, [15] zero
    output logic [2:0]           m_tuser    // [2:0] match_kind
);

    // Configuration registers
    logic [CFG_W-1:0]  query_low_reg;
    logic [CFG_W-1:0]  query_high_reg;
    logic [QLEN_W-1:0] query_len_reg;

    // Input register
    logic              in_valid_reg;
    logic [CHAR_W-1:0] in_char_reg;
    logic              in_last_reg;
    logic              in_empty_reg;

    // Candidate state
    logic [QLEN_W-1:0] query_idx_reg,  query_idx_next;
    logic [RUN_W-1:0]  run_score_reg,  run_score_next;
    logic [STRK_W-1:0] streak_reg,     streak_next;
    logic [POS_W-1:0]  char_pos_reg,   char_pos_next;
    logic              prefix_ok_reg,  prefix_ok_next;
    logic              overflow_reg,   overflow_next;

    // Output register
    logic               out_valid_reg;
    logic [SCORE_W-1:0] out_score_reg, out_score_next;
    kind_t              out_kind_reg,  out_kind_next;

    // Datapath signals
    logic [QLEN_W-1:0] qlen_eff;
    logic [CHAR_W-1:0] query_bytes [QUERY_MAX];
    logic [CHAR_W-1:0] cand_c;
    logic [15:0]       step_sum;
    logic [15:0]       len_diff;
    logic              item_ends;
    logic              out_free;
    logic              proc_fire;

    // Configuration writes; an index beyond the list is ignored
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_low_reg  <= '0;
            query_high_reg <= '0;
            query_len_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                CFG_QUERY_LOW:  query_low_reg  <= cfg_wdata;
                CFG_QUERY_HIGH: query_high_reg <= cfg_wdata;
                CFG_QUERY_LEN:  query_len_reg  <= cfg_wdata[QLEN_W-1:0];
                default: ;
            endcase
        end
    end

    // Folded query bytes and clamped length
    always_comb begin
        for (int i = 0; i < QUERY_MAX; i++) begin
            if (i < 8) begin
                query_bytes[i] = fold_byte(query_low_reg[(i % 8) * 8 +: 8]);
            end else begin
                query_bytes[i] = fold_byte(query_high_reg[(i % 8) * 8 +: 8]);
            end
        end
        qlen_eff = (query_len_reg > QLEN_W'(QUERY_MAX)) ? QLEN_W'(QUERY_MAX) : query_len_reg;
    end

    // Handshake: a final item needs room in the output register
    assign item_ends = in_empty_reg || in_last_reg;
    assign out_free  = !out_valid_reg || m_tready;
    assign proc_fire = in_valid_reg && (!item_ends || out_free);
    assign s_tready  = !in_valid_reg || proc_fire;

    // Input register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            in_char_reg  <= s_tdata;
            in_last_reg  <= s_tlast;
            in_empty_reg <= s_tuser;
        end
    end

    // Candidate state update for one byte
    always_comb begin
        query_idx_next = query_idx_reg;
        run_score_next = run_score_reg;
        streak_next    = streak_reg;
        char_pos_next  = char_pos_reg;
        prefix_ok_next = prefix_ok_reg;
        overflow_next  = overflow_reg;
        cand_c         = fold_byte(in_char_reg);
        step_sum = {2'b00, run_score_reg} - {8'd0, char_pos_reg} + BONUS_BASE
                 + ({11'd0, streak_reg} << 3) + ({11'd0, streak_reg} << 1);
        if (!in_empty_reg) begin
            if (char_pos_reg >= POS_W'(CANDIDATE_MAX)) begin
                overflow_next = 1'b1;
            end else begin
                if ({3'd0, char_pos_reg[QLEN_W-1:0]} == char_pos_reg
                    && char_pos_reg[QLEN_W-1:0] < qlen_eff
                    && cand_c != query_bytes[char_pos_reg[QIDX_W-1:0]]) begin
                    prefix_ok_next = 1'b0;
                end
                if (query_idx_reg < qlen_eff) begin
                    if (cand_c == query_bytes[query_idx_reg[QIDX_W-1:0]]) begin
                        // Negative sums clamp to zero
                        run_score_next = step_sum[15] ? '0 : step_sum[RUN_W-1:0];
                        streak_next    = streak_reg + STRK_W'(1);
                        query_idx_next = query_idx_reg + QLEN_W'(1);
                    end else begin
                        streak_next = '0;
                    end
                end
                char_pos_next = char_pos_reg + POS_W'(1);
            end
        end
    end

    // Result for a candidate that ends with this item
    always_comb begin
        len_diff = {2'b00, run_score_next} - {8'd0, char_pos_next};
        if (qlen_eff == '0) begin
            out_score_next = SCORE_EMPTY_QUERY;
            out_kind_next  = KIND_EMPTY;
        end else if (overflow_next) begin
            out_score_next = SCORE_NONE;
            out_kind_next  = KIND_OVERLONG;
        end else if (prefix_ok_next && char_pos_next == {3'd0, qlen_eff}) begin
            out_score_next = SCORE_EXACT;
            out_kind_next  = KIND_EXACT;
        end else if (prefix_ok_next && char_pos_next > {3'd0, qlen_eff}) begin
            out_score_next = SCORE_W'(SCORE_PREFIX - {8'd0, char_pos_next});
            out_kind_next  = KIND_PREFIX;
        end else if (query_idx_next >= qlen_eff) begin
            out_score_next = len_diff[SCORE_W-1:0];
            out_kind_next  = KIND_SUBSEQ;
        end else begin
            out_score_next = SCORE_NONE;
            out_kind_next  = KIND_NONE;
        end
    end

    // Candidate state registers; cleared after every result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            query_idx_reg <= '0;
            run_score_reg <= SCORE_START;
            streak_reg    <= '0;
            char_pos_reg  <= '0;
            prefix_ok_reg <= 1'b1;
            overflow_reg  <= 1'b0;
        end else if (proc_fire) begin
            if (item_ends) begin
                query_idx_reg <= '0;
                run_score_reg <= SCORE_START;
                streak_reg    <= '0;
                char_pos_reg  <= '0;
                prefix_ok_reg <= 1'b1;
                overflow_reg  <= 1'b0;
            end else begin
                query_idx_reg <= query_idx_next;
                run_score_reg <= run_score_next;
                streak_reg    <= streak_next;
                char_pos_reg  <= char_pos_next;
                prefix_ok_reg <= prefix_ok_next;
                overflow_reg  <= overflow_next;
            end
        end
    end

    // Output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (out_free) begin
            out_valid_reg <= proc_fire && item_ends;
        end
    end

    always_ff @(posedge aclk) begin
        if (proc_fire && item_ends) begin
            out_score_reg <= out_score_next;
            out_kind_reg  <= out_kind_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {1'b0, out_score_reg};
    assign m_tuser  = out_kind_reg;

    // Checks on the candidate state and results
    a_idx_le_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        {3'd0, query_idx_reg} <= char_pos_reg)
        else $error("more query bytes matched than candidate bytes taken");

    a_streak_le_idx: assert property (@(posedge aclk) disable iff (!aresetn)
        streak_reg <= query_idx_reg)
        else $error("match streak longer than the matched query bytes");

    a_overflow_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        overflow_reg |-> char_pos_reg == POS_W'(CANDIDATE_MAX))
        else $error("overlong flag set below the length bound");

    a_exact_score: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == KIND_EXACT) |-> m_tdata[SCORE_W-1:0] == SCORE_EXACT)
        else $error("exact match result with wrong score");

    a_result_needs_end: assert property (@(posedge aclk) disable iff (!aresetn)
        (proc_fire && !item_ends && !m_tvalid) |=> !m_tvalid)
        else $error("result raised by an item that does not end a candidate");

endmodule

>>> tb/fuzzy_subsequence_scorer_core_tb.sv
// Self-checking testbench for the fuzzy subsequence scorer core: directed and random candidates.
module fuzzy_subsequence_scorer_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import fss_pkg::*;

    // Scoring rules
    localparam int Q_BOUND          = 16;
    localparam int CAND_BOUND       = 255;
    localparam int START_SC         = 4000;
    localparam int EXACT_SC         = 10000;
    localparam int PREFIX_SC        = 8000;
    localparam int EMPTY_Q_SC       = 10;
    localparam int BONUS_FIXED      = 20;
    localparam int BONUS_PER_STREAK = 10;

    // Run control
    localparam int RANDOM_ITEMS  = 1800;
    localparam int SETTLE_CYCLES = 6;
    localparam int HOLD_LEN      = 300;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct packed {
        logic [14:0] score;
        kind_t       kind;
    } score_result_t;

    // Tracks the candidate being scored and queues the score each finished candidate should give
    class match_scoreboard;
        logic [CFG_W-1:0] qry_lo;
        logic [CFG_W-1:0] qry_hi;
        logic [4:0]       qry_len;
        int unsigned      q_idx;
        int unsigned      run_score;
        int unsigned      streak;
        int unsigned      cand_len;
        bit               prefix_ok;
        bit               overlong;
        score_result_t    expected_scores[$];
        int unsigned      results_checked;
        int unsigned      mismatches;
        int unsigned      kind_count[6];

        function new();
            qry_lo          = '0;
            qry_hi          = '0;
            qry_len         = '0;
            results_checked = 0;
            mismatches      = 0;
            foreach (kind_count[k]) kind_count[k] = 0;
            clear_candidate();
        endfunction

        function void write_reg(cfg_idx_t idx, logic [CFG_W-1:0] val);
            case (idx)
                CFG_QUERY_LOW:  qry_lo = val;
                CFG_QUERY_HIGH: qry_hi = val;
                CFG_QUERY_LEN:  qry_len = val[4:0];
                default: ;
            endcase
        endfunction

        function void clear_candidate();
            q_idx     = 0;
            run_score = START_SC;
            streak    = 0;
            cand_len  = 0;
            prefix_ok = 1'b1;
            overlong  = 1'b0;
        endfunction

        function logic [7:0] lower(logic [7:0] c);
            if (c >= 8'h41 && c <= 8'h5a) return c + 8'h20;
            return c;
        endfunction

        function int unsigned active_len();
            return (qry_len > Q_BOUND) ? Q_BOUND : qry_len;
        endfunction

        function logic [7:0] qry_byte(int unsigned i);
            logic [CFG_W-1:0] w;
            w = (i < 8) ? qry_lo : qry_hi;
            return lower(w[(i % 8) * 8 +: 8]);
        endfunction

        // One candidate byte: prefix check plus greedy in-order match
        function void take_byte(logic [7:0] raw);
            logic [7:0]  c;
            int unsigned n;
            int          s;
            c = lower(raw);
            n = active_len();
            if (cand_len >= CAND_BOUND) begin
                overlong = 1'b1;
                return;
            end
            if (cand_len < n && c != qry_byte(cand_len)) prefix_ok = 1'b0;
            if (q_idx < n) begin
                if (c == qry_byte(q_idx)) begin
                    s = int'(run_score) - int'(cand_len) + BONUS_FIXED
                        + int'(streak) * BONUS_PER_STREAK;
                    if (s < 0) s = 0;
                    run_score = s & 16'h3fff;
                    streak    = (streak + 1) % 32;
                    q_idx     = (q_idx + 1) % 32;
                end else begin
                    streak = 0;
                end
            end
            cand_len++;
        endfunction

        function void note_item(logic [7:0] c, logic l, logic e);
            score_result_t r;
            int unsigned   n;
            int            sc;
            if (!e) take_byte(c);
            if (!e && !l) return;
            n = active_len();
            if (n == 0) begin
                sc = EMPTY_Q_SC;
                r.kind = KIND_EMPTY;
            end else if (overlong) begin
                sc = -1;
                r.kind = KIND_OVERLONG;
            end else if (prefix_ok && cand_len == n) begin
                sc = EXACT_SC;
                r.kind = KIND_EXACT;
            end else if (prefix_ok && cand_len > n) begin
                sc = PREFIX_SC - int'(cand_len);
                r.kind = KIND_PREFIX;
            end else if (q_idx >= n) begin
                sc = int'(run_score) - int'(cand_len);
                r.kind = KIND_SUBSEQ;
            end else begin
                sc = -1;
                r.kind = KIND_NONE;
            end
            r.score = 15'(sc);
            expected_scores.insert(expected_scores.size(), r);
            clear_candidate();
        endfunction

        function void check_result(logic [15:0] d, logic [2:0] k);
            score_result_t want;
            results_checked++;
            if (expected_scores.size() == 0) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: result with no candidate pending: score %0d kind %0d",
                             $time, $signed(d[14:0]), k);
                return;
            end
            want = expected_scores.pop_front();
            kind_count[want.kind]++;
            if (d !== {1'b0, want.score} || k !== want.kind) begin
                mismatches++;
                if (mismatches <= 10)
                    $display("%0t ERROR: expected score %0d kind %0d, got tdata %h kind %0d",
                             $time, $signed(want.score), want.kind, d, k);
            end
        endfunction
    endclass

    // Block ports
    logic             aclk;
    logic             aresetn   = 1'b0;
    logic             cfg_wr_en = 1'b0;
    cfg_idx_t         cfg_index = CFG_QUERY_LOW;
    logic [CFG_W-1:0] cfg_wdata = '0;
    logic             s_tvalid  = 1'b0;
    logic             s_tready;
    logic [7:0]       s_tdata   = '0;   // [7:0] candidate_char
    logic             s_tlast   = 1'b0; // last_char
    logic             s_tuser   = 1'b0; // [0] empty_candidate
    logic             m_tvalid;
    logic             m_tready  = 1'b0;
    logic [15:0]      m_tdata;          // [14:0] match_score, [15] zero
    logic [2:0]       m_tuser;          // [2:0] match_kind

    // Stimulus state
    match_scoreboard sb;
    logic [7:0]      qry [16];
    int unsigned     qry_len_set = 0;
    logic [7:0]      cand[$];
    bit              tx_idle_on  = 1'b1;
    bit              rx_idle_on  = 1'b1;
    bit              hold_req    = 1'b0;
    int unsigned     items_sent  = 0;
    int unsigned     phase       = 0;

    fuzzy_subsequence_scorer_core dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("fuzzy_subsequence_scorer_core_tb failed");
        $finish;
    end

    // Handshake monitor: check results, predict from accepted items
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tuser);
            if (s_tvalid && s_tready) sb.note_item(s_tdata, s_tlast, s_tuser);
        end
    end

    // Result side: random back-pressure, plus one long hold-off on request
    initial begin
        int unsigned hold_cycles;
        forever begin
            @(posedge aclk);
            if (hold_req) begin
                m_tready <= 1'b0;
                hold_cycles = 0;
                while (hold_cycles < HOLD_LEN) begin
                    @(posedge aclk);
                    hold_cycles++;
                end
                hold_req = 1'b0;
            end else if (rx_idle_on && $urandom_range(0, 99) < 15) begin
                m_tready <= 1'b0;
            end else begin
                m_tready <= 1'b1;
            end
        end
    end

    // Adds one byte to the end of the candidate buffer
    function automatic void append_byte(logic [7:0] b);
        cand.insert(cand.size(), b);
    endfunction

    function automatic logic [7:0] flip_case(logic [7:0] c);
        if (c >= 8'h61 && c <= 8'h7a && $urandom_range(0, 1)) return c - 8'h20;
        if (c >= 8'h41 && c <= 8'h5a && $urandom_range(0, 1)) return c + 8'h20;
        return c;
    endfunction

    // Mostly a small letter alphabet so matches are common
    function automatic logic [7:0] query_like();
        int unsigned r;
        r = $urandom_range(0, 15);
        if (r < 10) return flip_case(8'h61 + 8'($urandom_range(0, 5)));
        if (r < 12) return 8'h30 + 8'($urandom_range(0, 9));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] noise_byte();
        if ($urandom_range(0, 1)) return query_like();
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic int unsigned pick_mode();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 15) return 0;
        if (r < 30) return 1;
        if (r < 60) return 2;
        if (r < 70) return 3;
        if (r < 78) return 6;
        if (r < 90) return 4;
        if (r < 98) return 5;
        return 7;
    endfunction

    // Shapes a candidate from the current query:
    // 0 exact, 1 prefix, 2 subsequence, 3 subsequence missing one byte,
    // 4 noise, 5 zero length, 6 short prefix, 7 around the length bound
    function automatic void build_candidate(int unsigned mode);
        int unsigned n;
        int unsigned skip;
        int unsigned total;
        n = (qry_len_set > Q_BOUND) ? Q_BOUND : qry_len_set;
        cand.delete();
        case (mode)
            0, 1: begin
                for (int i = 0; i < n; i++) append_byte(flip_case(qry[i]));
                if (mode == 1) repeat ($urandom_range(1, 6)) append_byte(noise_byte());
            end
            2, 3: begin
                skip = (mode == 3 && n > 0) ? $urandom_range(0, n - 1) : Q_BOUND;
                for (int i = 0; i < n; i++) begin
                    repeat ($urandom_range(0, 3)) append_byte(noise_byte());
                    if (i != skip) append_byte(flip_case(qry[i]));
                end
                repeat ($urandom_range(0, 2)) append_byte(noise_byte());
            end
            4: repeat ($urandom_range(1, 20)) append_byte(noise_byte());
            5: ;
            6: begin
                total = (n > 0) ? $urandom_range(0, n - 1) : 0;
                for (int i = 0; i < total; i++) append_byte(flip_case(qry[i]));
            end
            default: begin
                total = CAND_BOUND - 1 + $urandom_range(0, 7);
                for (int i = 0; i < n; i++) append_byte(flip_case(qry[i]));
                while (cand.size() < total) append_byte(noise_byte());
            end
        endcase
    endfunction

    // Write all three query registers, starting at a random one
    task automatic set_query(input logic [4:0] len);
        logic [CFG_W-1:0] lo;
        logic [CFG_W-1:0] hi;
        logic [CFG_W-1:0] val;
        cfg_idx_t         idx;
        int unsigned      first;
        for (int i = 0; i < 8; i++) begin
            lo[i*8 +: 8] = qry[i];
            hi[i*8 +: 8] = qry[i+8];
        end
        first = $urandom_range(0, 2);
        for (int j = 0; j < 3; j++) begin
            idx = cfg_idx_t'((first + j) % 3);
            case (idx)
                CFG_QUERY_LOW:  val = lo;
                CFG_QUERY_HIGH: val = hi;
                default:        val = CFG_W'(len);
            endcase
            cfg_wr_en <= 1'b1;
            cfg_index <= idx;
            cfg_wdata <= val;
            sb.write_reg(idx, val);
            @(posedge aclk);
        end
        cfg_wr_en   <= 1'b0;
        qry_len_set = len;
    endtask

    task automatic send_item(input logic [7:0] c, input logic l, input logic e);
        if (tx_idle_on && $urandom_range(0, 99) < 8) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= l;
        s_tuser  <= e;
        @(posedge aclk);
        while (!s_tready) @(posedge aclk);
        items_sent++;
    endtask

    // Send the buffered candidate, closed by tlast or by a trailing empty item
    task automatic send_candidate(input bit close_with_empty);
        int unsigned len;
        len = cand.size();
        for (int i = 0; i < len; i++)
            send_item(cand[i], (i == len - 1) && !close_with_empty, 1'b0);
        if (len == 0 || close_with_empty)
            send_item(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
    endtask

    // Stop sending and wait for every pending score, then let the pipeline settle
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (sb.expected_scores.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    initial begin
        int unsigned random_start;
        sb = new();
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: query "aBc"
        foreach (qry[i]) qry[i] = 8'($urandom_range(0, 255));
        qry[0] = 8'h61;
        qry[1] = 8'h42;
        qry[2] = 8'h63;
        set_query(5'd3);
        cand = '{8'h41, 8'h62, 8'h43};                        // exact, other case
        send_candidate(1'b0);
        cand = '{8'h61, 8'h62, 8'h63, 8'h5a};                 // prefix
        send_candidate(1'b0);
        cand = '{8'h78, 8'h61, 8'h79, 8'h62, 8'h7a, 8'h63};   // subsequence
        send_candidate(1'b0);
        cand.delete();                                        // zero length
        send_candidate(1'b0);
        cand = '{8'h71};                                      // ended by an empty item
        send_candidate(1'b1);
        cand = '{8'h00, 8'hff, 8'h40, 8'h5b, 8'h60, 8'h7b};   // fold boundaries, no match
        send_candidate(1'b0);
        drain();
        // Empty query
        set_query(5'd0);
        cand = '{8'h61};
        send_candidate(1'b0);
        drain();
        // Length beyond the bound, zero-length candidate
        set_query(5'd17);
        cand.delete();
        send_candidate(1'b0);
        drain();

        // Random phases, each with its own query setting
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_ITEMS) begin
            foreach (qry[i]) qry[i] = query_like();
            tx_idle_on = !(phase == 1);
            rx_idle_on = tx_idle_on;
            case (phase % 10)
                0: set_query(5'd0);
                1: set_query(5'd16);
                2: set_query(5'd31);
                3: set_query(5'd1);
                4: set_query(5'($urandom_range(17, 30)));
                5: begin
                    foreach (qry[i]) qry[i] = 8'hff;
                    set_query(5'($urandom_range(1, 4)));
                end
                6: begin
                    foreach (qry[i]) qry[i] = 8'h00;
                    set_query(5'($urandom_range(1, 4)));
                end
                default: set_query(5'($urandom_range(2, 6)));
            endcase

            // Long result hold-off while single-byte candidates pile up
            if (phase == 2) begin
                hold_req = 1'b1;
                repeat (40) begin
                    cand.delete();
                    append_byte(query_like());
                    send_candidate(1'b0);
                end
            end
            // Over the length bound, with and without an empty query
            if (phase % 10 <= 1) begin
                build_candidate(7);
                while (cand.size() <= CAND_BOUND) append_byte(noise_byte());
                send_candidate(1'b0);
            end
            repeat (25) begin
                build_candidate(pick_mode());
                send_candidate($urandom_range(0, 4) == 0);
            end
            drain();
            phase++;
        end

        repeat (SETTLE_CYCLES) @(posedge aclk);
        $display("Covered %0d items, %0d scores checked over %0d random query settings",
                 items_sent, sb.results_checked, phase);
        $display("Kinds seen: empty %0d exact %0d prefix %0d subseq %0d none %0d overlong %0d",
                 sb.kind_count[0], sb.kind_count[1], sb.kind_count[2],
                 sb.kind_count[3], sb.kind_count[4], sb.kind_count[5]);
        if (sb.mismatches == 0 && sb.expected_scores.size() == 0) begin
            $display("fuzzy_subsequence_scorer_core_tb passed");
        end else begin
            $display("%0d mismatches, %0d scores never arrived",
                     sb.mismatches, sb.expected_scores.size());
            $display("fuzzy_subsequence_scorer_core_tb failed");
        end
        $finish;
    end

endmodule
